FILE: sv/chaos_expansion_evaluator_unit_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the chaos expansion evaluator
// Clocked implication checks, disabled while reset is asserted.
// ----------------------------------------------------------------------------
`ifndef CHAOS_EXPANSION_EVALUATOR_UNIT_ASSERT_SVH
`define CHAOS_EXPANSION_EVALUATOR_UNIT_ASSERT_SVH

// Same-cycle implication
`define CEE_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("chaos expansion evaluator: same-cycle check failed");

// Next-cycle implication
`define CEE_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("chaos expansion evaluator: next-cycle check failed");

`endif

FILE: sv/cee_pkg.sv
// ----------------------------------------------------------------------------
// Chaos expansion evaluator package
// Command and register codes, multiplier handshake types, reciprocal table.
// ----------------------------------------------------------------------------
package cee_pkg;

    // Command codes
    localparam logic [1:0] CMD_LOAD = 2'd0;
    localparam logic [1:0] CMD_SET  = 2'd1;
    localparam logic [1:0] CMD_EVAL = 2'd2;

    // Configuration register indexes
    localparam logic [1:0] CFG_BASIS = 2'd0;
    localparam logic [1:0] CFG_TERMS = 2'd1;
    localparam logic [1:0] CFG_DIMS  = 2'd2;

    // Basis kinds
    localparam logic [1:0] BASIS_HERMITE  = 2'd0;
    localparam logic [1:0] BASIS_LEGENDRE = 2'd1;
    localparam logic [1:0] BASIS_LAGUERRE = 2'd2;
    localparam logic [1:0] BASIS_MONOMIAL = 2'd3;

    // Q32.32 constants
    localparam logic [63:0] ONE_Q = 64'h0000_0001_0000_0000;
    localparam logic [63:0] MAX_Q = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] MIN_Q = 64'h8000_0000_0000_0000;

    // Multiplier request and response
    typedef struct packed {
        logic        start;
        logic [63:0] a;
        logic [63:0] b;
    } t_mul_req;

    typedef struct packed {
        logic        done;
        logic        sat;
        logic [63:0] res;
    } t_mul_rsp;

    // round(2^32 / n) in Q32.32
    function automatic logic [63:0] f_recip(input logic [4:0] n);
        logic [63:0] r;
        unique case (n)
            5'd1:    r = 64'd4294967296;
            5'd2:    r = 64'd2147483648;
            5'd3:    r = 64'd1431655765;
            5'd4:    r = 64'd1073741824;
            5'd5:    r = 64'd858993459;
            5'd6:    r = 64'd715827883;
            5'd7:    r = 64'd613566757;
            5'd8:    r = 64'd536870912;
            5'd9:    r = 64'd477218588;
            5'd10:   r = 64'd429496730;
            5'd11:   r = 64'd390451572;
            5'd12:   r = 64'd357913941;
            5'd13:   r = 64'd330382100;
            5'd14:   r = 64'd306783378;
            5'd15:   r = 64'd286331153;
            5'd16:   r = 64'd268435456;
            default: r = 64'd0;
        endcase
        return r;
    endfunction

    // Saturating add or subtract, returns {sat, value}
    function automatic logic [64:0] f_sat_addsub(input logic [63:0] a, input logic [63:0] b,
                                                 input logic sub);
        logic [64:0] s;
        logic [64:0] r;
        s = sub ? ({a[63], a} - {b[63], b}) : ({a[63], a} + {b[63], b});
        if (s[64] != s[63]) begin
            r = {1'b1, (s[64] ? MIN_Q : MAX_Q)};
        end else begin
            r = {1'b0, s[63:0]};
        end
        return r;
    endfunction

endpackage

FILE: sv/cee_ram.sv
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module cee_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                     i_clk,
    input  logic                                     i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                         i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: sv/cee_qmul.sv
// ----------------------------------------------------------------------------
// Q32.32 multiplier
// Sign-magnitude product from four 32x32 partial products, one per cycle,
// rounded half away from zero and clamped to the signed 64-bit range.
// ----------------------------------------------------------------------------
module cee_qmul import cee_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_mul_req i_req,
    output t_mul_rsp o_rsp
);

    logic [63:0]  r_ma;
    logic [63:0]  r_mb;
    logic         r_neg;
    logic [127:0] r_acc;
    logic [2:0]   r_cnt;
    logic         r_busy;
    logic         r_done;
    logic         r_sat;
    logic [63:0]  r_res;

    logic [31:0]  w_ah;
    logic [31:0]  w_bh;
    logic [63:0]  w_pp;
    logic [1:0]   w_sh;
    logic [127:0] w_addend;
    logic [63:0]  w_r;
    logic [63:0]  w_lim;
    logic         w_ovf;

    // Select halves and align the partial product
    assign w_ah     = r_cnt[1] ? r_ma[63:32] : r_ma[31:0];
    assign w_bh     = r_cnt[0] ? r_mb[63:32] : r_mb[31:0];
    assign w_pp     = w_ah * w_bh;
    assign w_sh     = 2'(r_cnt[1]) + 2'(r_cnt[0]);
    assign w_addend = 128'(w_pp) << {w_sh, 5'd0};

    // Round already folded into the accumulator start value
    assign w_r   = r_acc[95:32];
    assign w_lim = r_neg ? MIN_Q : MAX_Q;
    assign w_ovf = (|r_acc[127:96]) || (w_r > w_lim);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= 3'd0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_ma   <= i_req.a[63] ? (64'd0 - i_req.a) : i_req.a;
                r_mb   <= i_req.b[63] ? (64'd0 - i_req.b) : i_req.b;
                r_neg  <= i_req.a[63] ^ i_req.b[63];
                r_acc  <= 128'h8000_0000;
                r_cnt  <= 3'd0;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                if (!r_cnt[2]) begin
                    r_acc <= r_acc + w_addend;
                    r_cnt <= r_cnt + 3'd1;
                end else begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                    r_sat  <= w_ovf;
                    if (w_ovf) begin
                        r_res <= w_lim;
                    end else begin
                        r_res <= r_neg ? (64'd0 - w_r) : w_r;
                    end
                end
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.sat  = r_sat;
    assign o_rsp.res  = r_res;

endmodule

FILE: sv/chaos_expansion_evaluator_unit.sv
// ----------------------------------------------------------------------------
// Chaos expansion evaluator
// Sums coefficient times basis product over the configured number of terms, Q32.32 saturating.
// ----------------------------------------------------------------------------
// Usage:
//   An item is taken when i_start is high and o_busy is low. i_command picks
//   load term (writes coefficient and orders at i_term_index), set coordinate
//   (writes i_coord_value at i_dim_index) or evaluate.
//   Every item gives one result: o_valid is high for one cycle with o_value
//   and o_status. Load, set and unused commands answer zero the cycle after
//   they are taken and never raise o_busy.
//   Evaluate raises o_busy until its result. Every product runs through one
//   shared Q32.32 multiplier, and the sequencer waits for each product
//   before it issues the next. Configuration writes on i_cfg_we take effect
//   at once. Reset clears coordinates and registers (basis Hermite, one term,
//   one dimension); the term store holds garbage until loaded. The receiver
//   cannot stall: each result shows for exactly one cycle.
// ----------------------------------------------------------------------------
module chaos_expansion_evaluator_unit import cee_pkg::*; #(
    parameter int MAX_TERMS = 64,
    parameter int MAX_DIMS  = 4,
    parameter int MAX_ORDER = 7
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    output logic        o_busy,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [6:0]  i_cfg_data,
    input  logic [1:0]  i_command,
    input  logic [5:0]  i_term_index,
    input  logic signed [31:0] i_coefficient,
    input  logic [2:0]  i_order_zero,
    input  logic [2:0]  i_order_one,
    input  logic [2:0]  i_order_two,
    input  logic [2:0]  i_order_three,
    input  logic [1:0]  i_dim_index,
    input  logic signed [31:0] i_coord_value,
    output logic        o_valid,
    output logic signed [63:0] o_value,
    output logic        o_status
);

    localparam int AW  = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
    localparam int TW  = $clog2(MAX_TERMS + 1);
    localparam int DCW = $clog2(MAX_DIMS + 1);
    localparam int CW  = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
    localparam int RW  = 44;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_RD    = 4'd1;
    localparam logic [3:0] S_TERM  = 4'd2;
    localparam logic [3:0] S_DIM   = 4'd3;
    localparam logic [3:0] S_MONO  = 4'd4;
    localparam logic [3:0] S_MONOR = 4'd5;
    localparam logic [3:0] S_REC0  = 4'd6;
    localparam logic [3:0] S_REC1  = 4'd7;
    localparam logic [3:0] S_REC1C = 4'd8;
    localparam logic [3:0] S_REC2  = 4'd9;
    localparam logic [3:0] S_REC3  = 4'd10;
    localparam logic [3:0] S_REC4  = 4'd11;
    localparam logic [3:0] S_PSI   = 4'd12;
    localparam logic [3:0] S_COEF  = 4'd13;
    localparam logic [3:0] S_WAIT  = 4'd14;
    localparam logic [3:0] S_DONE  = 4'd15;

    logic [3:0]  r_state;
    logic [3:0]  r_ret;
    logic [1:0]  r_basis;
    logic [6:0]  r_term_count;
    logic [2:0]  r_dim_count;
    logic [31:0] r_coord [MAX_DIMS];
    logic [TW-1:0]  r_t;
    logic [DCW-1:0] r_d;
    logic [3:0]  r_k;
    logic [3:0]  r_ord;
    logic [31:0] r_coef;
    logic [11:0] r_orders;
    logic [63:0] r_x;
    logic [63:0] r_p0;
    logic [63:0] r_p1;
    logic [63:0] r_c;
    logic [63:0] r_a;
    logic [63:0] r_psi;
    logic [63:0] r_sum;
    logic        r_sat;
    logic        r_valid;
    logic [63:0] r_value;
    logic        r_status;

    logic        w_take;
    logic        w_load_we;
    logic [15:0] w_tidx16;
    logic [15:0] w_nt16;
    logic [15:0] w_nd16;
    logic [TW-1:0]  w_nt;
    logic [DCW-1:0] w_nd;
    logic [RW-1:0]  w_rdata;
    logic [2:0]  w_ord_raw;
    logic [3:0]  w_ord;
    logic [63:0] w_xd;
    logic [63:0] w_k2;
    logic [63:0] w_kq;
    logic [64:0] w_sub_a;
    logic [64:0] w_lag1;
    logic [64:0] w_lagc;
    logic [64:0] w_sum_n;
    logic [4:0]  w_kp1;
    t_mul_req    w_req;
    t_mul_rsp    w_rsp;

    assign w_take    = i_start && (r_state == S_IDLE);
    assign w_tidx16  = 16'(i_term_index);
    assign w_load_we = w_take && (i_command == CMD_LOAD) && (w_tidx16 < 16'(MAX_TERMS));

    // Clamp counts to the store sizes
    assign w_nt16 = (16'(r_term_count) > 16'(MAX_TERMS)) ? 16'(MAX_TERMS) : 16'(r_term_count);
    assign w_nd16 = (16'(r_dim_count) > 16'(MAX_DIMS)) ? 16'(MAX_DIMS) : 16'(r_dim_count);
    assign w_nt   = w_nt16[TW-1:0];
    assign w_nd   = w_nd16[DCW-1:0];

    // Term store: coefficient over four 3-bit orders
    cee_ram #(
        .WIDTH (RW),
        .DEPTH (MAX_TERMS)
    ) u_terms (
        .i_clk   (i_clk),
        .i_we    (w_load_we),
        .i_waddr (w_tidx16[AW-1:0]),
        .i_wdata ({i_coefficient, i_order_three, i_order_two, i_order_one, i_order_zero}),
        .i_raddr (r_t[AW-1:0]),
        .o_rdata (w_rdata)
    );

    // Order of the current dimension, clamped
    always_comb begin
        unique case (16'(r_d))
            16'd0:   w_ord_raw = r_orders[2:0];
            16'd1:   w_ord_raw = r_orders[5:3];
            16'd2:   w_ord_raw = r_orders[8:6];
            16'd3:   w_ord_raw = r_orders[11:9];
            default: w_ord_raw = 3'd0;
        endcase
    end
    assign w_ord = (4'(w_ord_raw) > 4'(MAX_ORDER)) ? 4'(MAX_ORDER) : 4'(w_ord_raw);

    // Recurrence operands
    assign w_xd    = {{16{r_coord[r_d[CW-1:0]][31]}}, r_coord[r_d[CW-1:0]], 16'd0};
    assign w_k2    = {27'd0, r_k, 1'b1, 32'd0};
    assign w_kq    = {28'd0, r_k, 32'd0};
    assign w_kp1   = 5'(r_k) + 5'd1;
    assign w_sub_a = f_sat_addsub(r_a, w_rsp.res, 1'b1);
    assign w_lag1  = f_sat_addsub(ONE_Q, w_xd, 1'b1);
    assign w_lagc  = f_sat_addsub(w_k2, r_x, 1'b1);
    assign w_sum_n = f_sat_addsub(r_sum, w_rsp.res, 1'b0);

    // Multiplier requests by issuing state
    always_comb begin
        w_req.start = 1'b0;
        w_req.a     = r_p1;
        w_req.b     = r_x;
        unique case (r_state)
            S_MONO: begin
                w_req.start = (r_k != r_ord);
            end
            S_REC0: begin
                w_req.start = (r_k != r_ord) && (r_basis != BASIS_LAGUERRE);
                w_req.a     = r_x;
                w_req.b     = (r_basis == BASIS_LEGENDRE) ? w_k2 : r_p1;
            end
            S_REC1C: begin
                w_req.start = 1'b1;
                w_req.a     = r_c;
                w_req.b     = r_p1;
            end
            S_REC2: begin
                w_req.start = 1'b1;
                w_req.a     = r_p0;
                w_req.b     = w_kq;
            end
            S_REC3: begin
                w_req.start = (r_basis != BASIS_HERMITE);
                w_req.a     = w_sub_a[63:0];
                w_req.b     = f_recip(w_kp1);
            end
            S_PSI: begin
                w_req.start = 1'b1;
                w_req.a     = r_psi;
                w_req.b     = r_p1;
            end
            S_COEF: begin
                w_req.start = 1'b1;
                w_req.a     = {{16{r_coef[31]}}, r_coef, 16'd0};
                w_req.b     = r_psi;
            end
            default: begin
                w_req.start = 1'b0;
            end
        endcase
    end

    cee_qmul u_qmul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .o_rsp   (w_rsp)
    );

    // Configuration registers and coordinates
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_basis      <= BASIS_HERMITE;
            r_term_count <= 7'd1;
            r_dim_count  <= 3'd1;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_BASIS: r_basis      <= i_cfg_data[1:0];
                CFG_TERMS: r_term_count <= i_cfg_data;
                CFG_DIMS:  r_dim_count  <= i_cfg_data[2:0];
                default:   r_basis      <= r_basis;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < MAX_DIMS; i++) begin
            if (!i_rst_n) begin
                r_coord[i] <= 32'd0;
            end else if (w_take && (i_command == CMD_SET) &&
                         (16'(i_dim_index) == 16'(i))) begin
                r_coord[i] <= i_coord_value;
            end
        end
    end

    // Sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_valid <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (w_take) begin
                        r_sum <= 64'd0;
                        r_sat <= 1'b0;
                        r_t   <= '0;
                        if (i_command == CMD_EVAL) begin
                            r_state <= (w_nt == '0) ? S_DONE : S_RD;
                        end else begin
                            r_valid  <= 1'b1;
                            r_value  <= 64'd0;
                            r_status <= 1'b0;
                        end
                    end
                end
                S_RD: begin
                    r_state <= S_TERM;
                end
                S_TERM: begin
                    r_coef   <= w_rdata[43:12];
                    r_orders <= w_rdata[11:0];
                    r_psi    <= ONE_Q;
                    r_d      <= '0;
                    r_state  <= (w_nd == '0) ? S_COEF : S_DIM;
                end
                S_DIM: begin
                    r_x   <= w_xd;
                    r_ord <= w_ord;
                    r_p0  <= ONE_Q;
                    if (w_ord == 4'd0) begin
                        r_p1    <= ONE_Q;
                        r_state <= S_PSI;
                    end else if (r_basis == BASIS_MONOMIAL) begin
                        r_p1    <= ONE_Q;
                        r_k     <= 4'd0;
                        r_state <= S_MONO;
                    end else begin
                        r_k <= 4'd1;
                        if (r_basis == BASIS_LAGUERRE) begin
                            r_p1  <= w_lag1[63:0];
                            r_sat <= r_sat | w_lag1[64];
                        end else begin
                            r_p1 <= w_xd;
                        end
                        r_state <= S_REC0;
                    end
                end
                S_MONO: begin
                    if (r_k == r_ord) begin
                        r_state <= S_PSI;
                    end else begin
                        r_ret   <= S_MONOR;
                        r_state <= S_WAIT;
                    end
                end
                S_MONOR: begin
                    r_p1    <= w_rsp.res;
                    r_k     <= r_k + 4'd1;
                    r_state <= S_MONO;
                end
                S_REC0: begin
                    if (r_k == r_ord) begin
                        r_state <= S_PSI;
                    end else if (r_basis == BASIS_LAGUERRE) begin
                        r_c     <= w_lagc[63:0];
                        r_sat   <= r_sat | w_lagc[64];
                        r_state <= S_REC1C;
                    end else if (r_basis == BASIS_LEGENDRE) begin
                        r_ret   <= S_REC1;
                        r_state <= S_WAIT;
                    end else begin
                        r_ret   <= S_REC2;
                        r_state <= S_WAIT;
                    end
                end
                S_REC1: begin
                    r_c     <= w_rsp.res;
                    r_state <= S_REC1C;
                end
                S_REC1C: begin
                    r_ret   <= S_REC2;
                    r_state <= S_WAIT;
                end
                S_REC2: begin
                    r_a     <= w_rsp.res;
                    r_ret   <= S_REC3;
                    r_state <= S_WAIT;
                end
                S_REC3: begin
                    r_sat <= r_sat | w_sub_a[64];
                    if (r_basis == BASIS_HERMITE) begin
                        r_p0    <= r_p1;
                        r_p1    <= w_sub_a[63:0];
                        r_k     <= r_k + 4'd1;
                        r_state <= S_REC0;
                    end else begin
                        r_ret   <= S_REC4;
                        r_state <= S_WAIT;
                    end
                end
                S_REC4: begin
                    r_p0    <= r_p1;
                    r_p1    <= w_rsp.res;
                    r_k     <= r_k + 4'd1;
                    r_state <= S_REC0;
                end
                S_PSI: begin
                    r_ret   <= S_DIM;
                    r_state <= S_WAIT;
                end
                S_COEF: begin
                    r_ret   <= S_RD;
                    r_state <= S_WAIT;
                end
                S_WAIT: begin
                    if (w_rsp.done) begin
                        if (r_ret == S_DIM) begin
                            // Fold basis value into the product, advance dimension
                            r_sat   <= r_sat | w_rsp.sat;
                            r_psi   <= w_rsp.res;
                            r_d     <= r_d + 1'b1;
                            r_state <= ((r_d + 1'b1) == w_nd) ? S_COEF : S_DIM;
                        end else if (r_ret == S_RD) begin
                            // Accumulate the term, advance term
                            r_sum   <= w_sum_n[63:0];
                            r_sat   <= r_sat | w_rsp.sat | w_sum_n[64];
                            r_t     <= r_t + 1'b1;
                            r_state <= ((r_t + 1'b1) == w_nt) ? S_DONE : S_RD;
                        end else begin
                            r_sat   <= r_sat | w_rsp.sat;
                            r_state <= r_ret;
                        end
                    end
                end
                S_DONE: begin
                    r_valid  <= 1'b1;
                    r_value  <= r_sum;
                    r_status <= r_sat;
                    r_state  <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_busy   = (r_state != S_IDLE);
    assign o_valid  = r_valid;
    assign o_value  = r_value;
    assign o_status = r_status;

`include "chaos_expansion_evaluator_unit_assert.svh"

    `CEE_ASSERT_NEXT(a_eval_busy, w_take && (i_command == CMD_EVAL), o_busy)
    `CEE_ASSERT_IMPL(a_no_strobe_busy, o_busy, !o_valid)
    `CEE_ASSERT_IMPL(a_mul_done_wait, w_rsp.done, r_state == S_WAIT)

endmodule

FILE: verif/tb_chaos_expansion_evaluator_unit.sv
// ----------------------------------------------------------------------------
// Chaos expansion evaluator testbench
// Drives load, set, evaluate and unused commands in bursts, shadows the term
// store, coordinates and registers, and checks every result in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_chaos_expansion_evaluator_unit;
    import cee_pkg::*;

    localparam logic [1:0] CMD_NONE = 2'd3;
    localparam int NUM_ITEMS   = 1170;
    localparam int CYCLE_LIMIT = 20_000_000;
    localparam logic signed [63:0] Q_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam logic signed [63:0] Q_MIN = 64'sh8000_0000_0000_0000;

    typedef struct {
        logic [1:0]         cmd;
        logic [5:0]         tidx;
        logic signed [31:0] coef;
        logic [2:0]         ord [4];
        logic [1:0]         didx;
        logic signed [31:0] cval;
    } t_item;

    typedef struct {
        logic signed [63:0] value;
        logic               status;
    } t_result;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_start = 1'b0;
    logic               o_busy;
    logic               i_cfg_we = 1'b0;
    logic [1:0]         i_cfg_idx = '0;
    logic [6:0]         i_cfg_data = '0;
    logic [1:0]         i_command = '0;
    logic [5:0]         i_term_index = '0;
    logic signed [31:0] i_coefficient = '0;
    logic [2:0]         i_order_zero = '0;
    logic [2:0]         i_order_one = '0;
    logic [2:0]         i_order_two = '0;
    logic [2:0]         i_order_three = '0;
    logic [1:0]         i_dim_index = '0;
    logic signed [31:0] i_coord_value = '0;
    logic               o_valid;
    logic signed [63:0] o_value;
    logic               o_status;

    chaos_expansion_evaluator_unit DUT (.*);

    always #4 i_clk = ~i_clk;

    // Shadow state of the block
    logic [1:0]         sh_basis = BASIS_HERMITE;
    logic [6:0]         sh_terms = 7'd1;
    logic [2:0]         sh_dims = 3'd1;
    logic signed [31:0] sh_coef [64];
    logic [2:0]         sh_ord [64][4];
    logic signed [31:0] sh_coord [4] = '{default: '0};
    logic               sh_sat;

    t_item   pending_items [$];
    t_result expected_results [$];
    int      mismatches = 0;
    int      cycle_count = 0;
    int      items_queued = 0;

    // Q32.32 product, magnitude rounded half away from zero, clamped
    function automatic logic signed [63:0] q_mul(input logic signed [63:0] a,
                                                 input logic signed [63:0] b);
        logic         neg;
        logic [63:0]  ma;
        logic [63:0]  mb;
        logic [127:0] r;
        neg = a[63] ^ b[63];
        ma = a[63] ? -a : a;
        mb = b[63] ? -b : b;
        r = (({64'd0, ma} * {64'd0, mb}) + (128'd1 << 31)) >> 32;
        if (r > (neg ? (128'd1 << 63) : ((128'd1 << 63) - 1))) begin
            sh_sat = 1'b1;
            return neg ? Q_MIN : Q_MAX;
        end
        return neg ? -r[63:0] : r[63:0];
    endfunction

    function automatic logic signed [63:0] q_addsub(input logic signed [63:0] a,
                                                    input logic signed [63:0] b,
                                                    input logic sub);
        logic signed [64:0] s;
        s = sub ? ({a[63], a} - {b[63], b}) : ({a[63], a} + {b[63], b});
        if (s > 65'sd9223372036854775807 || s < -65'sd9223372036854775808) begin
            sh_sat = 1'b1;
            return s[64] ? Q_MIN : Q_MAX;
        end
        return s[63:0];
    endfunction

    function automatic logic signed [63:0] q_int(input int n);
        return 64'(n) << 32;
    endfunction

    // Univariate basis polynomial by its recurrence
    function automatic logic signed [63:0] basis_value(input logic [1:0] kind,
                                                       input int order,
                                                       input logic signed [63:0] x);
        logic signed [63:0] p0;
        logic signed [63:0] p1;
        logic signed [63:0] p2;
        logic signed [63:0] c;
        logic signed [63:0] rcp;
        p0 = q_int(1);
        if (order == 0) return q_int(1);
        if (kind == BASIS_MONOMIAL) begin
            p1 = q_int(1);
            for (int k = 0; k < order; k++) p1 = q_mul(p1, x);
            return p1;
        end
        p1 = (kind == BASIS_LAGUERRE) ? q_addsub(q_int(1), x, 1'b1) : x;
        for (int k = 1; k < order; k++) begin
            rcp = ((64'd1 << 32) + 64'((k + 1) / 2)) / 64'(k + 1);
            if (kind == BASIS_HERMITE) begin
                p2 = q_addsub(q_mul(x, p1), q_mul(p0, q_int(k)), 1'b1);
            end else begin
                if (kind == BASIS_LEGENDRE) c = q_mul(x, q_int(2 * k + 1));
                else c = q_addsub(q_int(2 * k + 1), x, 1'b1);
                p2 = q_addsub(q_mul(c, p1), q_mul(p0, q_int(k)), 1'b1);
                p2 = q_mul(p2, rcp);
            end
            p0 = p1;
            p1 = p2;
        end
        return p1;
    endfunction

    // Update the shadow state with one item and return its result
    function automatic t_result apply_command(input t_item it);
        t_result            res;
        int                 nt;
        int                 nd;
        logic signed [63:0] psi;
        res.value = '0;
        res.status = 1'b0;
        case (it.cmd)
            CMD_LOAD: begin
                sh_coef[it.tidx] = it.coef;
                for (int d = 0; d < 4; d++) sh_ord[it.tidx][d] = it.ord[d];
            end
            CMD_SET: sh_coord[it.didx] = it.cval;
            CMD_EVAL: begin
                sh_sat = 1'b0;
                nt = (sh_terms > 64) ? 64 : int'(sh_terms);
                nd = (sh_dims > 4) ? 4 : int'(sh_dims);
                for (int t = 0; t < nt; t++) begin
                    psi = q_int(1);
                    for (int d = 0; d < nd; d++)
                        psi = q_mul(psi, basis_value(sh_basis, int'(sh_ord[t][d]),
                                                     64'(sh_coord[d]) <<< 16));
                    res.value = q_addsub(res.value, q_mul(64'(sh_coef[t]) <<< 16, psi), 1'b0);
                end
                res.status = sh_sat;
            end
            default: ;
        endcase
        return res;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("mismatch at cycle %0d: %s", cycle_count, msg);
        mismatches++;
    endtask

    // Driver: offer pending items in bursts with random gaps
    int    burst_left = 4;
    int    gap_left = 0;
    t_item cur_item;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_start <= 1'b0;
        end else begin
            if (i_start && !o_busy)
                expected_results.push_back(apply_command(cur_item));
            if (!i_start || !o_busy) begin
                if (gap_left > 0) begin
                    gap_left--;
                    i_start <= 1'b0;
                end else if (pending_items.size() > 0) begin
                    cur_item = pending_items.pop_front();
                    i_command <= cur_item.cmd;
                    i_term_index <= cur_item.tidx;
                    i_coefficient <= cur_item.coef;
                    i_order_zero <= cur_item.ord[0];
                    i_order_one <= cur_item.ord[1];
                    i_order_two <= cur_item.ord[2];
                    i_order_three <= cur_item.ord[3];
                    i_dim_index <= cur_item.didx;
                    i_coord_value <= cur_item.cval;
                    i_start <= 1'b1;
                    burst_left--;
                    if (burst_left <= 0) begin
                        burst_left = $urandom_range(1, 20);
                        gap_left = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 12) : 0;
                    end
                end else begin
                    i_start <= 1'b0;
                end
            end
        end
    end

    // Monitor: compare each result with the oldest expectation
    always @(posedge i_clk) begin
        t_result e;
        cycle_count <= cycle_count + 1;
        if (i_rst_n && o_valid) begin
            if (expected_results.size() == 0) begin
                report_mismatch("result with nothing expected");
            end else begin
                e = expected_results.pop_front();
                if (o_value !== e.value)
                    report_mismatch($sformatf("value %h, expected %h", o_value, e.value));
                if (o_status !== e.status)
                    report_mismatch($sformatf("status %b, expected %b", o_status, e.status));
            end
        end
    end

    // Hard stop
    always @(posedge i_clk) begin
        if (cycle_count > CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    task automatic wait_idle();
        do @(negedge i_clk);
        while (pending_items.size() != 0 || i_start || o_busy || expected_results.size() != 0);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [6:0] data);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= data;
        case (idx)
            CFG_BASIS: sh_basis = data[1:0];
            CFG_TERMS: sh_terms = data;
            default:   sh_dims = data[2:0];
        endcase
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic configure(input logic [1:0] basis, input logic [6:0] terms,
                             input logic [2:0] dims);
        wait_idle();
        write_reg(CFG_BASIS, {5'd0, basis});
        write_reg(CFG_TERMS, terms);
        write_reg(CFG_DIMS, {4'd0, dims});
    endtask

    function automatic logic signed [31:0] pick_value(input int span);
        case ($urandom_range(0, 5))
            0: return 32'($urandom);
            1: return $urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
            default: return 32'($signed($urandom_range(0, 2 * span)) - span);
        endcase
    endfunction

    task automatic queue_item(input logic [1:0] cmd, input logic [5:0] tidx,
                              input logic signed [31:0] coef, input logic [11:0] ords,
                              input logic [1:0] didx, input logic signed [31:0] cval);
        t_item it;
        it.cmd = cmd;
        it.tidx = tidx;
        it.coef = coef;
        for (int d = 0; d < 4; d++) it.ord[d] = ords[3 * d +: 3];
        it.didx = didx;
        it.cval = cval;
        pending_items.push_back(it);
        items_queued++;
    endtask

    task automatic queue_random(input int eval_pct);
        int r;
        r = $urandom_range(0, 99);
        if (r < eval_pct)
            queue_item(CMD_EVAL, 6'($urandom), 32'($urandom), 12'($urandom), 2'($urandom),
                       32'($urandom));
        else if (r < eval_pct + 5)
            queue_item(CMD_NONE, 6'($urandom), 32'($urandom), 12'($urandom), 2'($urandom),
                       32'($urandom));
        else if (r < eval_pct + 40)
            queue_item(CMD_SET, 6'($urandom), 32'($urandom), 12'($urandom), 2'($urandom),
                       pick_value(262144));
        else
            queue_item(CMD_LOAD, 6'($urandom), pick_value(196608), 12'($urandom),
                       2'($urandom), 32'($urandom));
    endtask

    initial begin
        int        nt;
        logic [6:0] terms;
        logic [2:0] dims;

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: extremes, every command, saturation, every basis
        queue_item(CMD_LOAD, 6'd0, 32'sh7FFF_FFFF, 12'hFFF, 2'd0, 32'sd0);
        queue_item(CMD_SET, 6'd0, 32'sd0, 12'd0, 2'd0, 32'sh0002_0000);
        queue_item(CMD_EVAL, 6'd0, 32'sd0, 12'd0, 2'd0, 32'sd0);
        queue_item(CMD_NONE, 6'h3F, 32'sh8000_0000, 12'hFFF, 2'd3, 32'sh7FFF_FFFF);
        queue_item(CMD_SET, 6'd0, 32'sd0, 12'd0, 2'd3, 32'sh7FFF_FFFF);
        queue_item(CMD_LOAD, 6'h3F, 32'sh8000_0000, 12'd0, 2'd0, 32'sd0);
        queue_item(CMD_SET, 6'd0, 32'sd0, 12'd0, 2'd0, 32'sh8000_0000);
        queue_item(CMD_EVAL, 6'd0, 32'sd0, 12'd0, 2'd0, 32'sd0);
        queue_item(CMD_SET, 6'd0, 32'sd0, 12'd0, 2'd0, 32'shFFFF_8000);
        for (int b = 0; b < 4; b++) begin
            configure(2'(b), 7'd1, 3'd1);
            queue_item(CMD_EVAL, 6'd0, 32'sd0, 12'd0, 2'd0, 32'sd0);
        end
        // Zero terms and zero dimensions
        configure(BASIS_LEGENDRE, 7'd0, 3'd0);
        queue_item(CMD_EVAL, 6'd0, 32'sd0, 12'd0, 2'd0, 32'sd0);

        // Fill every term slot so later evaluations read only written entries
        for (int t = 0; t < 64; t++)
            queue_item(CMD_LOAD, 6'(t), pick_value(196608), 12'($urandom), 2'd0, 32'sd0);
        for (int d = 0; d < 4; d++)
            queue_item(CMD_SET, 6'd0, 32'sd0, 12'd0, 2'(d), pick_value(131072));

        // Random phases, each under its own register setting
        while (items_queued < NUM_ITEMS) begin
            case ($urandom_range(0, 9))
                0: terms = 7'd127;
                1: terms = 7'd64;
                2: terms = 7'd0;
                default: terms = 7'($urandom_range(1, 6));
            endcase
            dims = ($urandom_range(0, 4) == 0) ? 3'($urandom_range(0, 7)) :
                                                3'($urandom_range(1, 4));
            configure(2'($urandom), terms, dims);
            nt = (terms >= 64) ? 3 : $urandom_range(10, 40);
            for (int i = 0; i < nt; i++) queue_random((terms >= 64) ? 10 : 30);
        end

        wait_idle();
        repeat (20) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
